### sv/calendar_schedule_table_assert.svh
// assertion macros for the schedule table
`ifndef CALENDAR_SCHEDULE_TABLE_ASSERT_SVH
`define CALENDAR_SCHEDULE_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// ante holds in a cycle, so cons holds in the same cycle
`define CST_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("schedule table check failed");

// ante holds in a cycle, so cons holds in the next one
`define CST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("schedule table check failed");

`else

`define CST_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CST_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/cst_pkg.sv
`default_nettype none

package cst_pkg;

   localparam int ID_W    = 8;
   localparam int PLAN_W  = 8;
   localparam int MONTH_W = 12;
   localparam int DAY_W   = 31;
   localparam int WEEK_W  = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } cst_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } cst_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } cst_state_type;

   typedef struct packed {
      logic [ID_W-1:0]    ident;
      logic [PLAN_W-1:0]  plan;
      logic [MONTH_W-1:0] months;
      logic [DAY_W-1:0]   days;
      logic [WEEK_W-1:0]  weekdays;
   } cst_entry_type;

   // all three masks must contain the date; position 0 or beyond the mask selects nothing
   function automatic logic date_hit(cst_entry_type e, logic [3:0] m, logic [4:0] d,
                                     logic [2:0] w);
      logic m_ok;
      logic d_ok;
      logic w_ok;
      m_ok = (m != 4'd0) && (m <= 4'd12) && e.months[m - 4'd1];
      d_ok = (d != 5'd0) && e.days[d - 5'd1];
      w_ok = (w != 3'd0) && e.weekdays[w - 3'd1];
      return m_ok && d_ok && w_ok;
   endfunction

endpackage

`default_nettype wire

### sv/cst_ram.sv
`default_nettype none

module cst_ram
   import cst_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int AW      = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire cst_entry_type wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output cst_entry_type      rd_data
);

   cst_entry_type mem_ff [ENTRIES];
   cst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/calendar_schedule_table.sv
// channel   | handshake          | words
// ----------+--------------------+-------------------------------------------------
// request   | start / busy       | req_type, req_schedule_id, req_interval_plan,
//           |                    | req_*_mask, req_now_month/day/weekday
// response  | rsp_valid (strobe) | rsp_status, rsp_found_plan
//
// clear answers in the cycle after start. add and lookup walk the entries through
// the one read port of the entry memory, one entry per cycle. delete walks up to the
// entry, then moves each later entry down one slot. reset is synchronous and empties
// the table.
// one request at a time: busy stays high until its response strobe is issued; a clear never raises it.
// the response is a one-cycle strobe; the receiver cannot hold it off.
`default_nettype none

module calendar_schedule_table
   import cst_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_schedule_id,
   input  wire logic [7:0]  req_interval_plan,
   input  wire logic [11:0] req_month_mask,
   input  wire logic [30:0] req_day_mask,
   input  wire logic [6:0]  req_weekday_mask,
   input  wire logic [3:0]  req_now_month,
   input  wire logic [4:0]  req_now_day,
   input  wire logic [2:0]  req_now_weekday,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_found_plan
);

`include "calendar_schedule_table_assert.svh"

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   cst_state_type  state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic [CW-1:0]  chk_idx_ff, chk_idx_in;
   logic           chk_vld_ff, chk_vld_in;

   cst_op_type     op_ff;
   logic [7:0]     id_ff;
   logic [7:0]     plan_ff;
   logic [11:0]    months_ff;
   logic [30:0]    days_ff;
   logic [6:0]     weekdays_ff;
   logic [3:0]     month_ff;
   logic [4:0]     day_ff;
   logic [2:0]     weekday_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   cst_status_type rsp_status_ff, rsp_status_in;
   logic [7:0]     rsp_plan_ff, rsp_plan_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   cst_entry_type  wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   cst_entry_type  rd_data;
   cst_entry_type  new_entry;

   logic           accept;
   logic           hit;
   logic           scan_end;
   logic           full;
   logic [CW-1:0]  shift_dst;

   cst_ram #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign scan_end = (rd_idx_ff >= count_ff);
   assign full     = (count_ff == CW'(ENTRIES));
   assign shift_dst = chk_idx_ff - CW'(1);
   assign new_entry = '{ident: id_ff, plan: plan_ff, months: months_ff,
                        days: days_ff, weekdays: weekdays_ff};

   // word read last cycle is checked against the request
   assign hit = chk_vld_ff &&
                ((op_ff == OP_LOOKUP) ? date_hit(rd_data, month_ff, day_ff, weekday_ff)
                                      : (rd_data.ident == id_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (cst_op_type'(req_type) != OP_CLEAR)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            priority if (hit && (op_ff == OP_DELETE)) begin
               state_in = S_SHIFT;
            end else if (hit || scan_end) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SHIFT: begin
            if (scan_end && !chk_vld_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = new_entry;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_plan_in   = rsp_plan_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_idx_in = '0;
               if (cst_op_type'(req_type) == OP_CLEAR) begin
                  count_in      = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_plan_in   = 8'd0;
               end
            end
         end
         S_SCAN: begin
            if (!scan_end) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff;
               rd_idx_in  = rd_idx_ff + CW'(1);
            end
            priority if (hit) begin
               chk_vld_in = 1'b0;
               unique case (op_ff)
                  OP_ADD: begin
                     // alter in place
                     wr_en         = 1'b1;
                     wr_addr       = chk_idx_ff[AW-1:0];
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_plan_in   = 8'd0;
                  end
                  OP_DELETE: begin
                     rd_en     = 1'b0;
                     rd_idx_in = chk_idx_ff + CW'(1);
                  end
                  OP_LOOKUP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_plan_in   = rd_data.plan;
                  end
                  OP_CLEAR: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_plan_in   = 8'd0;
                  end
               endcase
            end else if (scan_end) begin
               chk_vld_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_plan_in  = 8'd0;
               if (op_ff == OP_ADD) begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     // append behind the last entry
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[AW-1:0];
                     count_in      = count_ff + CW'(1);
                     rsp_status_in = ST_OK;
                  end
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end else begin
               rsp_valid_in = 1'b0;
            end
         end
         S_SHIFT: begin
            if (!scan_end) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff;
               rd_idx_in  = rd_idx_ff + CW'(1);
            end
            // entry read last cycle moves down one slot
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[AW-1:0];
               wr_data = rd_data;
            end
            if (scan_end && !chk_vld_ff) begin
               count_in      = count_ff - CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_plan_in   = 8'd0;
            end
         end
         default: begin
            chk_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_plan_ff   <= rsp_plan_in;
      if (accept) begin
         op_ff       <= cst_op_type'(req_type);
         id_ff       <= req_schedule_id;
         plan_ff     <= req_interval_plan;
         months_ff   <= req_month_mask;
         days_ff     <= req_day_mask;
         weekdays_ff <= req_weekday_mask;
         month_ff    <= req_now_month;
         day_ff      <= req_now_day;
         weekday_ff  <= req_now_weekday;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_plan = rsp_plan_ff;

   `CST_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(ENTRIES))
   `CST_ASSERT_NEXT(a_accept_moves, clock, reset, start && !busy, busy || rsp_valid)
   `CST_ASSERT_IMPLY(a_miss_no_plan, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_found_plan == 8'd0)
   `CST_ASSERT_IMPLY(a_write_busy, clock, reset, wr_en, state_ff != S_IDLE)

endmodule

`default_nettype wire

### tb/schedule_table_checker.sv
module schedule_table_checker
   import cst_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_schedule_id,
   input  wire logic [7:0]  req_interval_plan,
   input  wire logic [11:0] req_month_mask,
   input  wire logic [30:0] req_day_mask,
   input  wire logic [6:0]  req_weekday_mask,
   input  wire logic [3:0]  req_now_month,
   input  wire logic [4:0]  req_now_day,
   input  wire logic [2:0]  req_now_weekday,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [7:0]  rsp_found_plan,
   output int               mismatches,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]        status;
      logic [PLAN_W-1:0] plan;
   } answer_type;

   answer_type    answers_due[$];
   cst_entry_type slots[ENTRIES];
   int            live_count;

   // 1-based position into a mask of the given width; out of range never hits
   function automatic logic covers(logic [30:0] mask, int pos, int width);
      if (pos < 1 || pos > width) return 1'b0;
      return mask[pos - 1];
   endfunction

   function automatic answer_type predict_answer(
      cst_op_type op, logic [7:0] id, logic [7:0] plan, logic [11:0] mm,
      logic [30:0] dm, logic [6:0] wm, logic [3:0] mon, logic [4:0] day,
      logic [2:0] wd);
      answer_type ans;
      int         hit;
      int         i;
      ans.status = ST_OK;
      ans.plan   = '0;
      hit        = -1;
      for (i = 0; i < live_count; i++) begin
         if (hit < 0 && slots[i].ident == id) hit = i;
      end
      case (op)
         OP_ADD: begin
            if (hit < 0 && live_count >= ENTRIES) begin
               ans.status = ST_FULL;
            end else begin
               if (hit < 0) begin
                  hit = live_count;
                  slots[hit].ident = id;
                  live_count++;
               end
               slots[hit].plan     = plan;
               slots[hit].months   = mm;
               slots[hit].days     = dm;
               slots[hit].weekdays = wm;
            end
         end
         OP_DELETE: begin
            if (hit < 0) begin
               ans.status = ST_NOT_FOUND;
            end else begin
               for (i = hit; i < live_count - 1; i++) slots[i] = slots[i + 1];
               live_count--;
            end
         end
         OP_LOOKUP: begin
            ans.status = ST_NOT_FOUND;
            for (i = 0; i < live_count; i++) begin
               if (ans.status == ST_NOT_FOUND &&
                   covers({19'd0, slots[i].months}, mon, MONTH_W) &&
                   covers(slots[i].days, day, DAY_W) &&
                   covers({24'd0, slots[i].weekdays}, wd, WEEK_W)) begin
                  ans.status = ST_OK;
                  ans.plan   = slots[i].plan;
               end
            end
         end
         default: live_count = 0;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      answer_type due;
      if (reset) begin
         answers_due.delete();
         live_count = 0;
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $error("response word with nothing expected: status %0d plan %0d",
                      rsp_status, rsp_found_plan);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_found_plan !== due.plan) begin
                  $error("rsp_found_plan: expected %0d, actual %0d", due.plan,
                         rsp_found_plan);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            answers_due.push_back(predict_answer(cst_op_type'(req_type), req_schedule_id,
               req_interval_plan, req_month_mask, req_day_mask, req_weekday_mask,
               req_now_month, req_now_day, req_now_weekday));
         end
      end
      pending = answers_due.size();
   end

endmodule

### tb/tb_calendar_schedule_table.sv
module tb_calendar_schedule_table
   import cst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES        = 16;
   localparam int RANDOM_WORDS   = 1520;
   localparam int CALM_TAIL      = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [7:0]  req_schedule_id;
   logic [7:0]  req_interval_plan;
   logic [11:0] req_month_mask;
   logic [30:0] req_day_mask;
   logic [6:0]  req_weekday_mask;
   logic [3:0]  req_now_month;
   logic [4:0]  req_now_day;
   logic [2:0]  req_now_weekday;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_found_plan;
   int          mismatches;
   int          pending;
   int          stuck_cycles;
   logic [7:0]  id_salt;

   calendar_schedule_table #(.ENTRIES(ENTRIES)) dut (.*);

   schedule_table_checker #(.ENTRIES(ENTRIES)) checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: no word moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic issue_word(cst_op_type op, logic [7:0] id, logic [7:0] plan,
                             logic [11:0] mm, logic [30:0] dm, logic [6:0] wm,
                             logic [3:0] mon, logic [4:0] day, logic [2:0] wd);
      req_type          = op;
      req_schedule_id   = id;
      req_interval_plan = plan;
      req_month_mask    = mm;
      req_day_mask      = dm;
      req_weekday_mask  = wm;
      req_now_month     = mon;
      req_now_day       = day;
      req_now_weekday   = wd;
      start             = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic issue_lookup(logic [3:0] mon, logic [4:0] day, logic [2:0] wd);
      issue_word(OP_LOOKUP, 8'd0, 8'd0, '0, '0, '0, mon, day, wd);
   endtask

   task automatic idle_for(int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain;
      start = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [30:0] pick_mask(int width);
      logic [30:0] full;
      int          sel;
      full = {31{1'b1}} >> (31 - width);
      sel  = $urandom_range(99);
      if (sel < 60) return 31'($urandom) & full;
      if (sel < 75) return full;
      if (sel < 90) return 31'd1 << $urandom_range(width - 1);
      return '0;
   endfunction

   task automatic issue_random;
      cst_op_type op;
      int         sel;
      logic [7:0] id;
      logic [3:0] mon;
      logic [4:0] day;
      logic [2:0] wd;
      sel = $urandom_range(99);
      if (sel < 45)      op = OP_ADD;
      else if (sel < 72) op = OP_DELETE;
      else if (sel < 98) op = OP_LOOKUP;
      else               op = OP_CLEAR;
      // small id pool so alters and deletes hit; the salt moves it over all bits
      if ($urandom_range(99) < 10) id = 8'($urandom_range(255));
      else                         id = 8'($urandom_range(19)) ^ id_salt;
      if (op == OP_CLEAR || $urandom_range(99) < 3) id_salt = 8'($urandom_range(255));
      if ($urandom_range(99) < 88) begin
         mon = 4'($urandom_range(1, 12));
         day = 5'($urandom_range(1, 31));
         wd  = 3'($urandom_range(1, 7));
      end else begin
         mon = 4'($urandom_range(15));
         day = 5'($urandom_range(31));
         wd  = 3'($urandom_range(7));
      end
      issue_word(op, id, 8'($urandom_range(255)), 12'(pick_mask(MONTH_W)),
                 pick_mask(DAY_W), 7'(pick_mask(WEEK_W)), mon, day, wd);
   endtask

   initial begin : stimulus
      int k;
      int idle_pct;
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = OP_LOOKUP;
      req_schedule_id   = '0;
      req_interval_plan = '0;
      req_month_mask    = '0;
      req_day_mask      = '0;
      req_weekday_mask  = '0;
      req_now_month     = '0;
      req_now_day       = '0;
      req_now_weekday   = '0;
      id_salt           = '0;
      idle_pct          = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table
      issue_lookup(4'd1, 5'd1, 3'd1);
      issue_word(OP_DELETE, 8'd5, 8'd0, '0, '0, '0, 4'd0, 5'd0, 3'd0);
      issue_word(OP_CLEAR, 8'd0, 8'd0, '0, '0, '0, 4'd0, 5'd0, 3'd0);
      // fill all slots, then one more new id hits the full case
      for (k = 0; k < ENTRIES; k++) begin
         if (k == 0)
            issue_word(OP_ADD, 8'd0, 8'd0, 12'hFFF, 31'h7FFF_FFFF, 7'h7F, 4'd0, 5'd0, 3'd0);
         else if (k == ENTRIES - 1)
            issue_word(OP_ADD, 8'd255, 8'd255, '0, '0, '0, 4'd15, 5'd31, 3'd7);
         else
            issue_word(OP_ADD, 8'(k * 16), 8'(k * 17), 12'(pick_mask(MONTH_W)),
                       pick_mask(DAY_W), 7'(pick_mask(WEEK_W)), 4'd0, 5'd0, 3'd0);
      end
      issue_word(OP_ADD, 8'd200, 8'd1, 12'hFFF, 31'h7FFF_FFFF, 7'h7F, 4'd0, 5'd0, 3'd0);
      issue_lookup(4'd12, 5'd31, 3'd7);
      issue_lookup(4'd13, 5'd1, 3'd1);
      issue_lookup(4'd1, 5'd0, 3'd1);
      issue_lookup(4'd1, 5'd1, 3'd0);
      // alter the head entry in place so it only covers december
      issue_word(OP_ADD, 8'd0, 8'd99, 12'h800, 31'h7FFF_FFFF, 7'h7F, 4'd0, 5'd0, 3'd0);
      issue_lookup(4'd1, 5'd1, 3'd1);
      issue_word(OP_DELETE, 8'd0, 8'd0, '0, '0, '0, 4'd0, 5'd0, 3'd0);
      issue_word(OP_DELETE, 8'd0, 8'd0, '0, '0, '0, 4'd0, 5'd0, 3'd0);
      issue_lookup(4'd12, 5'd1, 3'd1);
      issue_word(OP_CLEAR, 8'd0, 8'd0, '0, '0, '0, 4'd0, 5'd0, 3'd0);
      issue_lookup(4'd12, 5'd31, 3'd7);
      drain();

      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 100 == 0) idle_pct = $urandom_range(1) ? 30 : 0;
         if (k == RANDOM_WORDS / 2) drain();
         issue_random();
         if (k < RANDOM_WORDS - CALM_TAIL && $urandom_range(99) < idle_pct)
            idle_for($urandom_range(1, 17));
      end

      drain();
      repeat (60) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
